// ===== hw/rtl/tcp_syn_header_generator_macros.svh =====
// Assertion macros shared by the TCP SYN header generator modules.
`ifndef TCP_SYN_HEADER_GENERATOR_MACROS_SVH
`define TCP_SYN_HEADER_GENERATOR_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define TSG_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define TSG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/tsg_pkg.sv =====
// Types and constants for the TCP SYN header generator.
package tsg_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 1024;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int COUNT_W             = 11;
   localparam int CSR_INDEX_W         = 3;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_ADDR  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DST_ADDR  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_PORT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DST_PORT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TTL       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDENT     = 3'd6;

   // Header word positions
   localparam logic [3:0] WORD_VER_LEN   = 4'd0;
   localparam logic [3:0] WORD_IDENT     = 4'd1;
   localparam logic [3:0] WORD_TTL_CK    = 4'd2;
   localparam logic [3:0] WORD_SRC_ADDR  = 4'd3;
   localparam logic [3:0] WORD_DST_ADDR  = 4'd4;
   localparam logic [3:0] WORD_PORTS     = 4'd5;
   localparam logic [3:0] WORD_SEQ       = 4'd6;
   localparam logic [3:0] WORD_ACK       = 4'd7;
   localparam logic [3:0] WORD_OFF_WIN   = 4'd8;
   localparam logic [3:0] WORD_TCP_CK    = 4'd9;

   // Header field constants
   localparam logic [7:0]  VER_IHL        = 8'h45;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [15:0] IP_LEN_BASE    = 16'd40;
   localparam logic [15:0] TCP_LEN_BASE   = 16'd20;
   localparam logic [15:0] TCP_OFF_FLAGS  = 16'h5002;

   // Configuration reset values
   localparam logic [15:0] WINDOW_RESET   = 16'd5840;
   localparam logic [7:0]  TTL_RESET      = 8'd255;
   localparam logic [15:0] IDENT_RESET    = 16'd54321;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       byte_present;
      logic       end_of_payload;
   } req_type;

   typedef struct packed {
      logic [31:0] header_word;
      logic [3:0]  word_number;
      logic        final_word;
      logic        payload_overflow;
   } rsp_type;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] destination_address;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [15:0] window_size;
      logic [7:0]  time_to_live;
      logic [15:0] packet_ident;
   } cfg_type;

   // One finished payload handed from front to back
   typedef struct packed {
      logic [15:0]        pay_sum;
      logic [COUNT_W-1:0] count;
      logic               overflow;
   } job_type;

endpackage

// ===== hw/rtl/tsg_queue.sv =====
// Small job queue between the payload front end and the header back end.
`include "tcp_syn_header_generator_macros.svh"
module tsg_queue
   import tsg_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_i,
   input  job_type push_data_i,
   output logic    full_o,
   input  logic    pop_i,
   output job_type pop_data_o,
   output logic    empty_o
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full_o     = (count_ff == CNT_W'(DEPTH));
   assign empty_o    = (count_ff == '0);
   assign do_push    = push_i && !full_o;
   assign do_pop     = pop_i && !empty_o;
   assign pop_data_o = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data_i;
      end
   end

   `TSG_ASSERT_IMPL(a_no_push_when_full, push_i, !full_o, "job pushed into full queue")
   `TSG_ASSERT_IMPL(a_count_bounded, 1'b1, count_ff <= CNT_W'(DEPTH), "queue count overrun")

endmodule

// ===== hw/rtl/tsg_front.sv =====
// Payload front end: running ones-complement sum, byte count and overflow flag.
module tsg_front
   import tsg_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    push_o,
   output job_type push_data_o,
   input  logic    full_i
);

   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   logic [15:0]        sum_ff, sum_in;
   logic [7:0]         held_ff, held_in;
   logic               odd_ff, odd_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic               accept, take;
   logic [15:0]        sum_nx;
   logic [7:0]         held_nx;
   logic               odd_nx;
   logic [COUNT_W-1:0] count_nx;
   logic               ovf_nx;

   assign req_ready = !full_i;
   assign accept    = req_valid && req_ready;
   assign take      = req_data.byte_present && (count_ff < COUNT_W'(MAX_PAYLOAD));

   always_comb begin
      sum_nx   = sum_ff;
      held_nx  = held_ff;
      odd_nx   = odd_ff;
      count_nx = count_ff;
      ovf_nx   = ovf_ff || (req_data.byte_present && !take);
      if (take) begin
         if (odd_ff) begin
            sum_nx = oc_add(sum_ff, {held_ff, req_data.payload_byte});
         end else begin
            held_nx = req_data.payload_byte;
         end
         odd_nx   = !odd_ff;
         count_nx = count_ff + 1'b1;
      end
   end

   always_comb begin
      sum_in   = sum_ff;
      held_in  = held_ff;
      odd_in   = odd_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (req_data.end_of_payload) begin
            sum_in   = '0;
            held_in  = '0;
            odd_in   = 1'b0;
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            sum_in   = sum_nx;
            held_in  = held_nx;
            odd_in   = odd_nx;
            count_in = count_nx;
            ovf_in   = ovf_nx;
         end
      end
   end

   // trailing odd byte is padded with a zero low byte
   assign push_o               = accept && req_data.end_of_payload;
   assign push_data_o.pay_sum  = oc_add(sum_nx, odd_nx ? {held_nx, 8'h00} : 16'h0000);
   assign push_data_o.count    = count_nx;
   assign push_data_o.overflow = ovf_nx;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         held_ff  <= '0;
         odd_ff   <= 1'b0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         held_ff  <= held_in;
         odd_ff   <= odd_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

// ===== hw/rtl/tsg_back.sv =====
// Header back end: checksum sums, folding and the ten-word output sequence.
`include "tcp_syn_header_generator_macros.svh"
module tsg_back
   import tsg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg_i,
   input  job_type job_i,
   input  logic    empty_i,
   output logic    pop_o,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SUM  = 4'b0010,
      ST_FOLD = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   function automatic logic [15:0] fold20(input logic [19:0] s);
      logic [16:0] x;
      x = {1'b0, s[15:0]} + {13'd0, s[19:16]};
      return x[15:0] + {15'd0, x[16]};
   endfunction

   state_type   state_ff, state_in;
   job_type     job_ff;
   logic [17:0] addr_sum_ff;
   logic [17:0] ip_part_ff;
   logic [18:0] tcp_part_ff;
   logic [15:0] ip_ck_ff, tcp_ck_ff;
   logic [3:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;
   logic        out_load;
   logic [15:0] ip_len, tcp_len;
   logic [19:0] ip_total, tcp_total;
   logic [31:0] word;

   assign pop_o    = (state_ff == ST_IDLE) && !empty_i;
   assign out_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign ip_len   = IP_LEN_BASE + 16'(job_ff.count);
   assign tcp_len  = TCP_LEN_BASE + 16'(job_ff.count);
   assign ip_total  = 20'(addr_sum_ff) + 20'(ip_part_ff);
   assign tcp_total = 20'(addr_sum_ff) + 20'(tcp_part_ff);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!empty_i) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM:  state_in = ST_FOLD;
         ST_FOLD: begin
            state_in = ST_EMIT;
            idx_in   = WORD_VER_LEN;
         end
         ST_EMIT: begin
            if (out_load) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == WORD_TCP_CK) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      unique case (idx_ff)
         WORD_VER_LEN:  word = {VER_IHL, 8'h00, ip_len};
         WORD_IDENT:    word = {cfg_i.packet_ident, 16'h0000};
         WORD_TTL_CK:   word = {cfg_i.time_to_live, PROTO_TCP, ip_ck_ff};
         WORD_SRC_ADDR: word = cfg_i.src_addr;
         WORD_DST_ADDR: word = cfg_i.destination_address;
         WORD_PORTS:    word = {cfg_i.src_port, cfg_i.dst_port};
         WORD_SEQ:      word = '0;
         WORD_ACK:      word = '0;
         WORD_OFF_WIN:  word = {TCP_OFF_FLAGS, cfg_i.window_size};
         WORD_TCP_CK:   word = {tcp_ck_ff, 16'h0000};
         default:       word = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= WORD_VER_LEN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_o) begin
         job_ff <= job_i;
      end
      if (state_ff == ST_SUM) begin
         addr_sum_ff <= 18'(cfg_i.src_addr[31:16]) + 18'(cfg_i.src_addr[15:0])
                      + 18'(cfg_i.destination_address[31:16])
                      + 18'(cfg_i.destination_address[15:0]);
         ip_part_ff  <= 18'({VER_IHL, 8'h00}) + 18'(ip_len) + 18'(cfg_i.packet_ident)
                      + 18'({cfg_i.time_to_live, PROTO_TCP});
         tcp_part_ff <= 19'(PROTO_TCP) + 19'(tcp_len) + 19'(cfg_i.src_port)
                      + 19'(cfg_i.dst_port) + 19'(TCP_OFF_FLAGS)
                      + 19'(cfg_i.window_size) + 19'(job_ff.pay_sum);
      end
      if (state_ff == ST_FOLD) begin
         ip_ck_ff  <= ~fold20(ip_total);
         tcp_ck_ff <= ~fold20(tcp_total);
      end
      if (out_load) begin
         rsp_data_ff.header_word      <= word;
         rsp_data_ff.word_number      <= idx_ff;
         rsp_data_ff.final_word       <= (idx_ff == WORD_TCP_CK);
         rsp_data_ff.payload_overflow <= job_ff.overflow;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TSG_ASSERT_IMPL(a_final_is_last_word, rsp_valid_ff && rsp_data_ff.final_word, rsp_data_ff.word_number == WORD_TCP_CK, "final flag on wrong word")
   `TSG_ASSERT_NEXT(a_pop_starts_sum, pop_o, state_ff == ST_SUM, "job popped without starting sums")

endmodule

// ===== hw/rtl/tcp_syn_header_generator.sv =====
// Top level of the TCP SYN header generator: configuration registers and the front/back split.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data (payload byte, present, end)
//   rsp      out        rsp_valid / rsp_ready  rsp_data (header word, number, final, overflow)
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// Payload bytes are taken at one per cycle; req_ready drops only while the job queue is full.
// Each packet then passes through the back end in order: pop, sum, fold and ten output words.
// A job queue, four entries deep by default, lets new payload arrive while earlier headers are still going out.
// Synchronous reset clears payload state and the queue and loads the register defaults.
// A stalled rsp_ready holds the current word; csr_ready is always high.
module tcp_syn_header_generator
   import tsg_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    push, full, pop, empty;
   job_type push_data, pop_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SRC_ADDR: cfg_in.src_addr            = csr_data;
            CSR_DST_ADDR: cfg_in.destination_address = csr_data;
            CSR_SRC_PORT: cfg_in.src_port            = csr_data[15:0];
            CSR_DST_PORT: cfg_in.dst_port            = csr_data[15:0];
            CSR_WINDOW:   cfg_in.window_size         = csr_data[15:0];
            CSR_TTL:      cfg_in.time_to_live        = csr_data[7:0];
            CSR_IDENT:    cfg_in.packet_ident        = csr_data[15:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_addr            <= '0;
         cfg_ff.destination_address <= '0;
         cfg_ff.src_port            <= '0;
         cfg_ff.dst_port            <= '0;
         cfg_ff.window_size         <= WINDOW_RESET;
         cfg_ff.time_to_live        <= TTL_RESET;
         cfg_ff.packet_ident        <= IDENT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tsg_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .push_o      (push),
      .push_data_o (push_data),
      .full_i      (full)
   );

   tsg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_i      (push),
      .push_data_i (push_data),
      .full_o      (full),
      .pop_i       (pop),
      .pop_data_o  (pop_data),
      .empty_o     (empty)
   );

   tsg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg_i     (cfg_ff),
      .job_i     (pop_data),
      .empty_i   (empty),
      .pop_o     (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
